@@ rtl/lalt_pkg.sv @@
// Shared types and constants for the login attempt lockout table.
// Used by lalt_cell, lalt_rule and login_attempt_lockout_table_top.
// No dependencies.
package lalt_pkg;

   // Lockout policy constants
   localparam int unsigned FAIL_LIMIT   = 5;
   localparam int unsigned LEVEL_MAX    = 4;
   localparam int unsigned BASE_LOCK_MS = 5 * 60 * 1000;
   localparam int unsigned MS_PER_S     = 1000;

   // Reciprocal of MS_PER_S: floor(x / 1000) == (x * MS_RECIP) >> RECIP_SHIFT for any 32-bit x
   localparam int unsigned RECIP_SHIFT = 38;
   localparam logic [63:0] RECIP_SCALE = 64'd1 << RECIP_SHIFT;
   localparam logic [28:0] MS_RECIP =
      29'((RECIP_SCALE + 64'(MS_PER_S) - 64'd1) / 64'(MS_PER_S));

   typedef enum logic [1:0] {
      DEC_ALLOW  = 2'd0,
      DEC_ASK    = 2'd1,
      DEC_LOCKED = 2'd2
   } decision_type;

   // One table entry, as held in one cell of the ring
   typedef struct packed {
      logic [31:0] address;
      logic [31:0] last_seen;
      logic [31:0] first_failure;
      logic [31:0] lock_until;
      logic [2:0]  failures;
      logic [2:0]  lock_level;
   } entry_type;

   // Outcome of one attempt applied to its entry
   typedef struct packed {
      entry_type    entry;
      decision_type decision;
      logic [31:0]  wait_ms;
      logic         round_up;
   } rule_result_type;

endpackage

@@ rtl/lalt_cell.sv @@
// One cell of the entry ring: holds a single table entry.
// Depends on lalt_pkg.
module lalt_cell
   import lalt_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      shift,
   input  entry_type entry_in,
   output entry_type entry_out
);

   entry_type entry_ff;

   // Entry moves one place along the ring on every shift
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else if (shift) begin
         entry_ff <= entry_in;
      end
   end

   assign entry_out = entry_ff;

endmodule

@@ rtl/lalt_rule.sv @@
// Lockout rule: applies one attempt to one entry and gives the new entry,
// the decision and the wait in ms. Depends on lalt_pkg.
module lalt_rule
   import lalt_pkg::*;
(
   input  entry_type       entry_in,
   input  logic [31:0]     now_ms,
   input  logic            credentials_ok,
   input  logic            credentials_present,
   input  logic [31:0]     failure_window_ms,
   input  logic [30:0]     max_lock_ms,
   output rule_result_type result
);

   always_comb begin
      entry_type    e;
      decision_type dec;
      logic [31:0]  wait_ms;
      logic         up;
      logic [31:0]  lock_delta;
      logic [2:0]   fail_cnt;
      logic [3:0]   lvl_sum;
      logic [2:0]   lvl;
      logic [31:0]  duration;

      e            = entry_in;
      e.last_seen  = now_ms;
      dec          = DEC_ASK;
      wait_ms      = '0;
      up           = 1'b0;
      lock_delta   = now_ms - entry_in.lock_until;
      fail_cnt     = '0;
      lvl_sum      = '0;
      lvl          = '0;
      duration     = '0;

      if (entry_in.lock_until != '0 && lock_delta[31]) begin
         // lock still pending: report remaining time, rounded up
         dec     = DEC_LOCKED;
         wait_ms = entry_in.lock_until - now_ms;
         up      = 1'b1;
      end else begin
         // expired lock: drop the count, keep the level
         if (entry_in.lock_until != '0) begin
            e.failures   = '0;
            e.lock_until = '0;
         end
         if (credentials_ok) begin
            e.failures      = '0;
            e.first_failure = '0;
            dec             = DEC_ALLOW;
         end else if (credentials_present) begin
            // open a new failure window when none is open or it has run out
            if (e.first_failure == '0 || (now_ms - e.first_failure) > failure_window_ms) begin
               e.failures      = '0;
               e.first_failure = now_ms;
            end
            fail_cnt = e.failures + 3'd1;
            if (fail_cnt >= 3'(FAIL_LIMIT)) begin
               e.failures = '0;
               lvl_sum    = {1'b0, e.lock_level} + 4'd1;
               if (lvl_sum > 4'(LEVEL_MAX)) begin
                  lvl = 3'(LEVEL_MAX);
               end else begin
                  lvl = lvl_sum[2:0];
               end
               e.lock_level = lvl;
               duration     = 32'(BASE_LOCK_MS) << (lvl - 3'd1);
               if (duration > {1'b0, max_lock_ms}) begin
                  duration = {1'b0, max_lock_ms};
               end
               e.lock_until = now_ms + duration;
               dec          = DEC_LOCKED;
               wait_ms      = duration;
            end else begin
               e.failures = fail_cnt;
            end
         end
      end

      result.entry    = e;
      result.decision = dec;
      result.wait_ms  = wait_ms;
      result.round_up = up;
   end

endmodule

@@ rtl/login_attempt_lockout_table_top.sv @@
// Top level of the login attempt lockout table: entry ring, sequencer, APB registers.
// Depends on lalt_pkg, lalt_cell and lalt_rule.

// An attempt is taken when start is high and busy is low. An attempt with a valid
// session is answered (allow) in the very next cycle and leaves busy low. Any other
// attempt makes two trips around the ring of TABLE_ENTRIES cells, one to find the
// source or the oldest entry and one to rewrite it, then the ms to s scaling
// multiply and the reply: busy stays high through all of these and rsp_strobe
// is high for one cycle right after. There is no result back-pressure:
// rsp_strobe marks a one-cycle transaction that must be taken. The table is cleared
// by reset itself, with no clearing pass.
module login_attempt_lockout_table_top
   import lalt_pkg::*;
#(
   parameter int TABLE_ENTRIES = 8
) (
   input  logic        clock,
   input  logic        reset,
   // attempt channel
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_source_ip,
   input  logic [31:0] req_now_ms,
   input  logic        req_session_valid,
   input  logic        req_credentials_ok,
   input  logic        req_credentials_present,
   // result channel
   output logic        rsp_strobe,
   output logic [1:0]  rsp_decision,
   output logic [21:0] rsp_retry_after_s,
   output logic [2:0]  rsp_slot_used,
   // APB register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int PROD_W = 32 + $bits(MS_RECIP);
   localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(TABLE_ENTRIES - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SEEK,
      ST_SCALE,
      ST_REPLY
   } state_type;

   // Configuration registers
   logic [31:0] window_ff;
   logic [30:0] max_lock_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= 32'd900000;
         max_lock_ff <= 31'd3600000;
      end else if (psel && penable && pwrite && pready) begin
         if (paddr[2]) begin
            max_lock_ff <= pwdata[30:0];
         end else begin
            window_ff <= pwdata;
         end
      end
   end

   assign pready = 1'b1;
   assign prdata = paddr[2] ? {1'b0, max_lock_ff} : window_ff;

   // Sequencer and result registers
   state_type          state_ff;
   logic [IDX_W-1:0]   step_ff;
   logic               found_ff;
   logic [IDX_W-1:0]   slot_ff;
   logic [IDX_W-1:0]   oldest_ff;
   logic [31:0]        oldest_seen_ff;
   logic [31:0]        ip_ff;
   logic [31:0]        now_ff;
   logic               cred_ok_ff;
   logic               cred_present_ff;
   decision_type       dec_ff;
   logic [31:0]        wait_ff;
   logic               round_up_ff;
   logic [PROD_W-1:0]  product_ff;
   logic               rsp_strobe_ff;
   logic [1:0]         rsp_decision_ff;
   logic [21:0]        rsp_retry_ff;
   logic [2:0]         rsp_slot_ff;

   entry_type          cell_out [TABLE_ENTRIES];
   entry_type          chain_in [TABLE_ENTRIES];
   entry_type          head;
   entry_type          fresh;
   entry_type          rule_entry;
   entry_type          tail_in;
   rule_result_type    rule_res;
   logic [IDX_W-1:0]   target;
   logic               write_hit;
   logic               shift;
   logic               accept;
   logic [IDX_W+2:0]   slot_wide;

   assign head   = cell_out[0];
   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign shift  = (state_ff == ST_SCAN) || (state_ff == ST_SEEK);

   // Entry handed to a new source: everything cleared but the address
   always_comb begin
      fresh         = '0;
      fresh.address = ip_ff;
   end

   assign target     = found_ff ? slot_ff : oldest_ff;
   assign rule_entry = found_ff ? head : fresh;
   assign write_hit  = (state_ff == ST_SEEK) && (step_ff == target);
   assign tail_in    = write_hit ? rule_res.entry : head;
   assign slot_wide  = {3'b000, target};

   lalt_rule u_rule (
      .entry_in            (rule_entry),
      .now_ms              (now_ff),
      .credentials_ok      (cred_ok_ff),
      .credentials_present (cred_present_ff),
      .failure_window_ms   (window_ff),
      .max_lock_ms         (max_lock_ff),
      .result              (rule_res)
   );

   // Ring of cells: cell 0 is the head, the head's entry re-enters at the tail
   for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_ring
      if (k == TABLE_ENTRIES - 1) begin : g_tail
         assign chain_in[k] = tail_in;
      end else begin : g_link
         assign chain_in[k] = cell_out[k+1];
      end
      lalt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift     (shift),
         .entry_in  (chain_in[k]),
         .entry_out (cell_out[k])
      );
   end

   // Sequencer: scan pass, rewrite pass, scaling multiply, reply
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= '0;
         found_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  ip_ff           <= req_source_ip;
                  now_ff          <= req_now_ms;
                  cred_ok_ff      <= req_credentials_ok;
                  cred_present_ff <= req_credentials_present;
                  if (req_session_valid) begin
                     rsp_strobe_ff   <= 1'b1;
                     rsp_decision_ff <= DEC_ALLOW;
                     rsp_retry_ff    <= '0;
                     rsp_slot_ff     <= '0;
                  end else begin
                     state_ff <= ST_SCAN;
                     step_ff  <= '0;
                     found_ff <= 1'b0;
                  end
               end
            end
            ST_SCAN: begin
               // first match wins; oldest by plain compare, lowest index on ties
               if (!found_ff && head.address == ip_ff) begin
                  found_ff <= 1'b1;
                  slot_ff  <= step_ff;
               end
               if (step_ff == '0) begin
                  oldest_ff      <= '0;
                  oldest_seen_ff <= head.last_seen;
               end else if (head.last_seen < oldest_seen_ff) begin
                  oldest_ff      <= step_ff;
                  oldest_seen_ff <= head.last_seen;
               end
               if (step_ff == LAST_STEP) begin
                  step_ff  <= '0;
                  state_ff <= ST_SEEK;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_SEEK: begin
               if (write_hit) begin
                  dec_ff      <= rule_res.decision;
                  wait_ff     <= rule_res.wait_ms;
                  round_up_ff <= rule_res.round_up;
               end
               if (step_ff == LAST_STEP) begin
                  step_ff  <= '0;
                  state_ff <= ST_SCALE;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_SCALE: begin
               product_ff <= wait_ff * MS_RECIP;
               state_ff   <= ST_REPLY;
            end
            ST_REPLY: begin
               rsp_strobe_ff   <= 1'b1;
               rsp_decision_ff <= dec_ff;
               rsp_retry_ff    <= 22'(product_ff[PROD_W-1:RECIP_SHIFT]) + 22'(round_up_ff);
               rsp_slot_ff     <= slot_wide[2:0];
               state_ff        <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_decision      = rsp_decision_ff;
   assign rsp_retry_after_s = rsp_retry_ff;
   assign rsp_slot_used     = rsp_slot_ff;

`ifndef SYNTHESIS
   // A table attempt keeps the block busy on the next cycle
   a_table_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_session_valid |=> busy)
      else $error("table attempt did not raise busy");

   // Only a lockout carries a wait
   a_retry_only_locked: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_decision != DEC_LOCKED |-> rsp_retry_after_s == '0)
      else $error("nonzero retry without lockout");

   // Search outcome holds steady through the rewrite pass
   a_target_stable: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEEK && $past(state_ff) == ST_SEEK |->
         $stable(found_ff) && $stable(slot_ff) && $stable(oldest_ff))
      else $error("target entry changed during rewrite pass");

   // A result only follows the reply step or a session bypass
   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_REPLY) ||
                     $past(start && !busy && req_session_valid))
      else $error("result strobe without a transaction behind it");
`endif

endmodule
